// ----- hw/rtl/chs_pkg.sv -----
`timescale 1ns / 1ps

package chs_pkg;

  localparam int INDEX_BITS = 10;
  localparam int MAX_KICKS  = 32;
  localparam int KEY_W      = 31;
  localparam int DEPTH      = 1 << INDEX_BITS;
  localparam int KICK_W     = 6;
  localparam int K_W        = $clog2(MAX_KICKS + 1);
  localparam int PATH_W     = (MAX_KICKS > 1) ? $clog2(MAX_KICKS) : 1;
  localparam int QDEPTH     = 2;

  localparam logic [1:0] FUNC_ADD = 2'd1;
  localparam logic [1:0] FUNC_DEL = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  typedef enum logic [1:0] {
    OP_FIND,
    OP_ADD,
    OP_DEL,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_KREAD,
    S_KCHK,
    S_SHIFT,
    S_FIN
  } state_t;

  function automatic logic [INDEX_BITS-1:0] home0(input logic [KEY_W-1:0] k);
    return k[INDEX_BITS-1:0];
  endfunction

  function automatic logic [INDEX_BITS-1:0] home1(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] s;
    s = k >> INDEX_BITS;
    return s[INDEX_BITS-1:0];
  endfunction

endpackage

// ----- hw/rtl/chs_front.sv -----
`timescale 1ns / 1ps

module chs_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              func,
  input  logic [chs_pkg::KEY_W-1:0] key,
  input  logic                    clearing,
  output logic                    q_valid,
  output chs_pkg::req_t           q_data,
  input  logic                    q_pop
);
  import chs_pkg::*;

  localparam int QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  req_t             fifo [QDEPTH];
  logic [QP_W-1:0]  wptr;
  logic [QP_W-1:0]  rptr;
  logic [QP_W:0]    count;
  req_t             req;
  logic             push;

  // Zero keys and the unused function code are sorted out here.
  always_comb begin
    req.key = key;
    if (key == '0) begin
      req.op = OP_ZERO;
    end else if (func == FUNC_ADD) begin
      req.op = OP_ADD;
    end else if (func == FUNC_DEL) begin
      req.op = OP_DEL;
    end else begin
      req.op = OP_FIND;
    end
  end

  assign in_stall = clearing || (count == (QP_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_data   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QP_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= (rptr == QP_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (QP_W+1)'(push) - (QP_W+1)'(q_pop);
    end
  end

endmodule

// ----- hw/rtl/chs_back.sv -----
`timescale 1ns / 1ps

module chs_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [chs_pkg::KICK_W-1:0] kick_limit,
  output logic                      clearing,
  input  logic                      q_valid,
  input  chs_pkg::req_t             q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      success,
  output logic [1:0]                status,
  output logic [chs_pkg::KICK_W-1:0] kicks_used
);
  import chs_pkg::*;

  logic [KEY_W-1:0] t0_mem [DEPTH];
  logic [KEY_W-1:0] t1_mem [DEPTH];
  logic [KEY_W-1:0] t0_rd, t1_rd;
  logic             t0_we, t1_we;
  logic [INDEX_BITS-1:0] t0_waddr, t1_waddr, t0_raddr, t1_raddr;
  logic [KEY_W-1:0] t0_wdata, t1_wdata;

  state_t state, state_next;
  logic [INDEX_BITS-1:0] clr_cnt, clr_cnt_next;
  op_t              op, op_next;
  logic [KEY_W-1:0] x, x_next;
  logic [KEY_W-1:0] cur, cur_next;
  logic [INDEX_BITS-1:0] t, t_next;
  logic [K_W-1:0]   k, k_next;
  logic [K_W-1:0]   j, j_next;
  logic [INDEX_BITS-1:0] path [MAX_KICKS];
  logic [KEY_W-1:0] pkey [MAX_KICKS];
  logic             path_we;
  logic [PATH_W-1:0] path_waddr;
  logic [INDEX_BITS-1:0] path_wslot;
  logic [KEY_W-1:0] path_wkey;

  logic             out_valid_next, success_next;
  logic [1:0]       status_next;
  logic [KICK_W-1:0] kicks_next;

  logic [K_W-1:0]   lim;
  logic [INDEX_BITS-1:0] t_calc;
  logic [KEY_W-1:0] occ;
  logic             revisit;
  logic [K_W-1:0]   jv;
  logic [KICK_W:0]  kick_sat;

  assign clearing = (state == S_CLEAR);
  assign lim = (int'(kick_limit) > MAX_KICKS) ? K_W'(MAX_KICKS) : K_W'(kick_limit);
  assign t_calc = k[0] ? home1(cur) : home0(cur);
  assign occ = k[0] ? t1_rd : t0_rd;
  assign kick_sat = (int'(k) > 63) ? (KICK_W+1)'(63) : (KICK_W+1)'(k);

  // A kick that lands on an occupied slot already on the path of the same
  // table means the walk would loop.
  always_comb begin
    revisit = 1'b0;
    jv = '0;
    for (int i = 0; i < MAX_KICKS; i++) begin
      jv = K_W'(i);
      if (jv < k && jv[0] == k[0] && path[i] == t) begin
        revisit = 1'b1;
      end
    end
  end

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    op_next        = op;
    x_next         = x;
    cur_next       = cur;
    t_next         = t;
    k_next         = k;
    j_next         = j;
    q_pop          = 1'b0;
    t0_we = 1'b0; t0_waddr = '0; t0_wdata = '0;
    t1_we = 1'b0; t1_waddr = '0; t1_wdata = '0;
    t0_raddr = t_calc;
    t1_raddr = t_calc;
    path_we = 1'b0; path_waddr = '0; path_wslot = '0; path_wkey = '0;
    out_valid_next = out_valid && out_stall;
    success_next   = success;
    status_next    = status;
    kicks_next     = kicks_used;

    unique case (state)
      S_CLEAR: begin
        t0_we = 1'b1; t0_waddr = clr_cnt;
        t1_we = 1'b1; t1_waddr = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == INDEX_BITS'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        t0_raddr = home0(q_data.key);
        t1_raddr = home1(q_data.key);
        if (q_valid && (!out_valid || !out_stall)) begin
          q_pop      = 1'b1;
          op_next    = q_data.op;
          x_next     = q_data.key;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        success_next = 1'b0;
        status_next  = ST_MISS;
        kicks_next   = '0;
        state_next   = S_IDLE;
        out_valid_next = 1'b1;
        unique case (op)
          OP_ZERO: begin
            status_next = ST_ZERO;
          end
          OP_FIND: begin
            if (t0_rd == x || t1_rd == x) begin
              success_next = 1'b1;
              status_next  = ST_DONE;
            end
          end
          OP_DEL: begin
            if (t0_rd == x) begin
              t0_we = 1'b1; t0_waddr = home0(x);
              success_next = 1'b1;
              status_next  = ST_DONE;
            end else if (t1_rd == x) begin
              t1_we = 1'b1; t1_waddr = home1(x);
              success_next = 1'b1;
              status_next  = ST_DONE;
            end
          end
          OP_ADD: begin
            priority if (t0_rd == x || t1_rd == x) begin
              status_next = ST_MISS;
            end else if (t0_rd == '0) begin
              t0_we = 1'b1; t0_waddr = home0(x); t0_wdata = x;
              success_next = 1'b1;
              status_next  = ST_DONE;
            end else if (t1_rd == '0) begin
              t1_we = 1'b1; t1_waddr = home1(x); t1_wdata = x;
              success_next = 1'b1;
              status_next  = ST_DONE;
            end else if (lim == '0) begin
              status_next = ST_FULL;
            end else begin
              path_we    = 1'b1;
              path_waddr = '0;
              path_wslot = home0(x);
              path_wkey  = t0_rd;
              cur_next   = t0_rd;
              k_next     = K_W'(1);
              out_valid_next = 1'b0;
              state_next = S_KREAD;
            end
          end
          default: ;
        endcase
      end
      S_KREAD: begin
        t_next     = t_calc;
        state_next = S_KCHK;
      end
      S_KCHK: begin
        if (occ == '0) begin
          if (k[0]) begin
            t1_we = 1'b1; t1_waddr = t; t1_wdata = cur;
          end else begin
            t0_we = 1'b1; t0_waddr = t; t0_wdata = cur;
          end
          j_next     = k - 1'b1;
          state_next = (k == K_W'(1)) ? S_FIN : S_SHIFT;
        end else if (revisit || k == lim) begin
          success_next   = 1'b0;
          status_next    = ST_FULL;
          kicks_next     = '0;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          path_we    = 1'b1;
          path_waddr = k[PATH_W-1:0];
          path_wslot = t;
          path_wkey  = occ;
          cur_next   = occ;
          k_next     = k + 1'b1;
          state_next = S_KREAD;
        end
      end
      S_SHIFT: begin
        // Each key on the path moves one step toward the free slot.
        if (j[0]) begin
          t1_we = 1'b1; t1_waddr = path[j[PATH_W-1:0]];
          t1_wdata = pkey[PATH_W'(j - 1'b1)];
        end else begin
          t0_we = 1'b1; t0_waddr = path[j[PATH_W-1:0]];
          t0_wdata = pkey[PATH_W'(j - 1'b1)];
        end
        j_next = j - 1'b1;
        if (j == K_W'(1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        t0_we = 1'b1; t0_waddr = home0(x); t0_wdata = x;
        success_next   = 1'b1;
        status_next    = ST_DONE;
        kicks_next     = kick_sat[KICK_W-1:0];
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (t0_we) begin
      t0_mem[t0_waddr] <= t0_wdata;
    end
    t0_rd <= t0_mem[t0_raddr];
  end

  always_ff @(posedge clk) begin
    if (t1_we) begin
      t1_mem[t1_waddr] <= t1_wdata;
    end
    t1_rd <= t1_mem[t1_raddr];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path[path_waddr] <= path_wslot;
      pkey[path_waddr] <= path_wkey;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    x          <= x_next;
    cur        <= cur_next;
    t          <= t_next;
    k          <= k_next;
    j          <= j_next;
    success    <= success_next;
    status     <= status_next;
    kicks_used <= kicks_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hw/rtl/cuckoo_hash_set.sv -----
`timescale 1ns / 1ps

// Two-table cuckoo hash set of nonzero 31-bit keys with contains, add and
// remove. After reset both tables are cleared one slot per cycle, all 1024
// slots, during which in_stall stays high. A small input queue takes new
// beats while the engine works. Contains, remove, duplicate adds and adds
// that find a free home slot pass through S_IDLE and S_LOOK with the
// registered table read; an add that must displace keys reads the table
// in S_KREAD and checks it in S_KCHK for each kick, writes one table slot
// per shift step in S_SHIFT and places the new key in S_FIN. An add that
// fails on a full path ends in S_KCHK after its last kick.
module cuckoo_hash_set (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [chs_pkg::KICK_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [chs_pkg::KEY_W-1:0]   key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        success,
  output logic [1:0]                  status,
  output logic [chs_pkg::KICK_W-1:0]  kicks_used
);
  import chs_pkg::*;

  logic [KICK_W-1:0] kick_limit;
  logic              clearing;
  logic              q_valid;
  logic              q_pop;
  req_t              q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kick_limit <= KICK_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      kick_limit <= cfg_data;
    end
  end

  chs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .key      (key),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  chs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .kick_limit (kick_limit),
    .clearing   (clearing),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .success    (success),
    .status     (status),
    .kicks_used (kicks_used)
  );

endmodule

// ----- hw/rtl/chs_checker.sv -----
`timescale 1ns / 1ps

module chs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       success,
  input logic [1:0]                 status,
  input logic [chs_pkg::KICK_W-1:0] kicks_used
);
  import chs_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(success) && $stable(status)
      && $stable(kicks_used))
    else $error("stalled result changed");

  a_success_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (success == (status == ST_DONE)))
    else $error("success and status disagree");

  a_kicks_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && kicks_used != '0 |-> success)
    else $error("kicks reported on a failed item");

endmodule

bind cuckoo_hash_set chs_checker u_chs_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .success    (success),
  .status     (status),
  .kicks_used (kicks_used)
);
